// File: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and types of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int ARENA_BYTES  = 4096;
   localparam int HEADER_BYTES = 32;
   localparam int MAX_BLOCKS   = 128;

   // request and response field width
   localparam int FIELD_W = 12;
   // block offset and capacity width
   localparam int OFF_W   = $clog2(ARENA_BYTES);
   localparam int WIDE_W  = (OFF_W > FIELD_W) ? OFF_W : FIELD_W;
   // room for sums of a few offsets and sizes
   localparam int SUM_W   = WIDE_W + 2;
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_FREE    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_TOO_LARGE     = 2'd1,
      STATUS_NOT_ALLOCATED = 2'd2,
      STATUS_ALREADY_FREED = 2'd3
   } status_type;

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] cap;
      logic             busy;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_WRITE,
      CELL_WRITE_ALL,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } cell_cmd_type;

endpackage

// File: sv/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One block table entry; rotates, deletes or is written by index.
// ----------------------------------------------------------------------------
module ffa_cell import ffa_pkg::*; (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [IDX_W-1:0] cell_idx,
   input  entry_type        next_entry,
   output entry_type        entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_ROTATE: begin
            entry_in = next_entry;
         end
         CELL_WRITE: begin
            if (cmd.idx == cell_idx) begin
               entry_in.cap  = cmd.entry.cap;
               entry_in.busy = cmd.entry.busy;
            end
         end
         CELL_WRITE_ALL: begin
            if (cmd.idx == cell_idx) begin
               entry_in = cmd.entry;
            end
         end
         // close the gap: everything at or above the index moves down one
         CELL_DELETE: begin
            if (cell_idx >= cmd.idx) begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: sv/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Request sequencer: scans the rotating cell chain and applies updates.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [FIELD_W-1:0] req_request_size,
   input  logic [FIELD_W-1:0] req_block_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [FIELD_W-1:0] rsp_data_address,
   input  entry_type          head,
   output cell_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_FINISH,
      ST_DEL_SUCC,
      ST_PRED,
      ST_DEL_CUR,
      ST_RESP
   } state_type;

   localparam logic [SUM_W-1:0] HDR   = SUM_W'(HEADER_BYTES);
   localparam logic [SUM_W-1:0] LIMIT = SUM_W'(ARENA_BYTES - 1);

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [OFF_W-1:0]   hit_off_ff, hit_off_in;
   logic [OFF_W-1:0]   last_off_ff, last_off_in;
   logic [OFF_W-1:0]   last_cap_ff, last_cap_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               cur_busy_ff, cur_busy_in;
   logic [OFF_W-1:0]   cur_cap_ff, cur_cap_in;
   logic               prev_busy_ff, prev_busy_in;
   logic [OFF_W-1:0]   prev_cap_ff, prev_cap_in;
   logic               pred_busy_ff, pred_busy_in;
   logic [OFF_W-1:0]   pred_cap_ff, pred_cap_in;
   logic               want_succ_ff, want_succ_in;
   logic               succ_valid_ff, succ_valid_in;
   logic               succ_busy_ff, succ_busy_in;
   logic [OFF_W-1:0]   succ_cap_ff, succ_cap_in;
   logic [OFF_W-1:0]   newcap_ff, newcap_in;
   status_type         status_ff, status_in;
   logic [FIELD_W-1:0] daddr_ff, daddr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic               slot_live;
   logic               slot_last;
   logic               merge_succ;
   logic [SUM_W-1:0]   size_w;
   logic [SUM_W-1:0]   head_cap_w;
   logic [SUM_W-1:0]   new_off_w;
   logic [SUM_W-1:0]   tail_need_w;
   logic [SUM_W-1:0]   merged_w;
   logic [SUM_W-1:0]   pred_merged_w;

   always_comb begin
      size_w        = SUM_W'(size_ff);
      head_cap_w    = SUM_W'(head.cap);
      slot_live     = CNT_W'(scan_ff) < count_ff;
      slot_last     = CNT_W'(scan_ff) == (count_ff - CNT_W'(1));
      new_off_w     = SUM_W'(last_off_ff) + HDR + SUM_W'(last_cap_ff);
      tail_need_w   = new_off_w + HDR + size_w;
      merge_succ    = succ_valid_ff && !succ_busy_ff;
      merged_w      = merge_succ ? (SUM_W'(cur_cap_ff) + SUM_W'(succ_cap_ff) + HDR)
                                 : SUM_W'(cur_cap_ff);
      pred_merged_w = SUM_W'(pred_cap_ff) + SUM_W'(newcap_ff) + HDR;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_off_in    = hit_off_ff;
      last_off_in   = last_off_ff;
      last_cap_in   = last_cap_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      cur_busy_in   = cur_busy_ff;
      cur_cap_in    = cur_cap_ff;
      prev_busy_in  = prev_busy_ff;
      prev_cap_in   = prev_cap_ff;
      pred_busy_in  = pred_busy_ff;
      pred_cap_in   = pred_cap_ff;
      want_succ_in  = want_succ_ff;
      succ_valid_in = succ_valid_ff;
      succ_busy_in  = succ_busy_ff;
      succ_cap_in   = succ_cap_ff;
      newcap_in     = newcap_ff;
      status_in     = status_ff;
      daddr_in      = daddr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      cmd           = '{op: CELL_HOLD, idx: '0, entry: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               size_in  = req_request_size;
               addr_in  = req_block_address;
               state_in = ST_START;
            end
         end
         ST_START: begin
            status_in     = STATUS_OK;
            daddr_in      = '0;
            scan_in       = '0;
            hit_in        = 1'b0;
            found_in      = 1'b0;
            want_succ_in  = 1'b0;
            succ_valid_in = 1'b0;
            state_in      = ST_RESP;
            unique case (kind_ff)
               KIND_ALLOC: begin
                  if (count_ff == '0) begin
                     // empty table: the first block goes at offset zero
                     if (HDR + size_w > LIMIT) begin
                        status_in = STATUS_TOO_LARGE;
                     end else begin
                        cmd.op         = CELL_WRITE_ALL;
                        cmd.idx        = '0;
                        cmd.entry.off  = '0;
                        cmd.entry.cap  = OFF_W'(size_ff);
                        cmd.entry.busy = 1'b1;
                        count_in       = CNT_W'(1);
                        daddr_in       = FIELD_W'(HDR);
                     end
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               KIND_FREE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_NOT_ALLOCATED;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               KIND_RELEASE: begin
                  count_in = '0;
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         ST_SCAN: begin
            // one full turn of the chain; the head cell holds entry scan_ff
            cmd.op = CELL_ROTATE;
            if (kind_ff == KIND_ALLOC) begin
               if (slot_live && !hit_ff && !head.busy &&
                   ((head_cap_w == size_w) || ((head_cap_w >= size_w) && slot_last))) begin
                  hit_in     = 1'b1;
                  hit_idx_in = scan_ff;
                  hit_off_in = head.off;
               end
               if (slot_last) begin
                  last_off_in = head.off;
                  last_cap_in = head.cap;
               end
            end else begin
               if (slot_live && !found_ff && (SUM_W'(head.off) + HDR == SUM_W'(addr_ff))) begin
                  found_in     = 1'b1;
                  idx_in       = scan_ff;
                  cur_busy_in  = head.busy;
                  cur_cap_in   = head.cap;
                  pred_busy_in = prev_busy_ff;
                  pred_cap_in  = prev_cap_ff;
                  want_succ_in = 1'b1;
               end
               if (want_succ_ff) begin
                  want_succ_in  = 1'b0;
                  succ_valid_in = slot_live;
                  succ_busy_in  = head.busy;
                  succ_cap_in   = head.cap;
               end
            end
            prev_busy_in = head.busy;
            prev_cap_in  = head.cap;
            scan_in      = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(MAX_BLOCKS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_RESP;
            if (kind_ff == KIND_ALLOC) begin
               if (hit_ff) begin
                  cmd.op         = CELL_WRITE;
                  cmd.idx        = hit_idx_ff;
                  cmd.entry.cap  = OFF_W'(size_ff);
                  cmd.entry.busy = 1'b1;
                  daddr_in       = FIELD_W'(SUM_W'(hit_off_ff) + HDR);
               end else if ((tail_need_w > LIMIT) || (count_ff >= CNT_W'(MAX_BLOCKS))) begin
                  status_in = STATUS_TOO_LARGE;
               end else begin
                  // append after the tail block
                  cmd.op         = CELL_WRITE_ALL;
                  cmd.idx        = count_ff[IDX_W-1:0];
                  cmd.entry.off  = OFF_W'(new_off_w);
                  cmd.entry.cap  = OFF_W'(size_ff);
                  cmd.entry.busy = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
                  daddr_in       = FIELD_W'(new_off_w + HDR);
               end
            end else if (!found_ff) begin
               status_in = STATUS_NOT_ALLOCATED;
            end else if (!cur_busy_ff) begin
               status_in = STATUS_ALREADY_FREED;
            end else begin
               cmd.op         = CELL_WRITE;
               cmd.idx        = idx_ff;
               cmd.entry.cap  = OFF_W'(merged_w);
               cmd.entry.busy = 1'b0;
               newcap_in      = OFF_W'(merged_w);
               state_in       = merge_succ ? ST_DEL_SUCC : ST_PRED;
            end
         end
         ST_DEL_SUCC: begin
            cmd.op   = CELL_DELETE;
            cmd.idx  = idx_ff + IDX_W'(1);
            count_in = count_ff - CNT_W'(1);
            state_in = ST_PRED;
         end
         ST_PRED: begin
            if ((idx_ff != '0) && !pred_busy_ff) begin
               cmd.op         = CELL_WRITE;
               cmd.idx        = idx_ff - IDX_W'(1);
               cmd.entry.cap  = OFF_W'(pred_merged_w);
               cmd.entry.busy = 1'b0;
               state_in       = ST_DEL_CUR;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DEL_CUR: begin
            cmd.op   = CELL_DELETE;
            cmd.idx  = idx_ff;
            count_in = count_ff - CNT_W'(1);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = daddr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      scan_ff       <= scan_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_off_ff    <= hit_off_in;
      last_off_ff   <= last_off_in;
      last_cap_ff   <= last_cap_in;
      found_ff      <= found_in;
      idx_ff        <= idx_in;
      cur_busy_ff   <= cur_busy_in;
      cur_cap_ff    <= cur_cap_in;
      prev_busy_ff  <= prev_busy_in;
      prev_cap_ff   <= prev_cap_in;
      pred_busy_ff  <= pred_busy_in;
      pred_cap_ff   <= pred_cap_in;
      want_succ_ff  <= want_succ_in;
      succ_valid_ff <= succ_valid_in;
      succ_busy_ff  <= succ_busy_in;
      succ_cap_ff   <= succ_cap_in;
      newcap_ff     <= newcap_in;
      status_ff     <= status_in;
      daddr_ff      <= daddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_data_address = rsp_addr_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count beyond table size");

   a_scan_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_ff == IDX_W'(MAX_BLOCKS - 1)) |=> state_ff == ST_FINISH)
      else $error("chain turn did not end in finish");

   a_delete_keeps_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL_SUCC || state_ff == ST_DEL_CUR) |-> count_ff > CNT_W'(1))
      else $error("merge would empty the table");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_START && $past(state_ff) != ST_START && !$past(reset))
         |-> (count_ff + CNT_W'(1) >= $past(count_ff)))
      else $error("block count dropped by more than one");

endmodule

// File: sv/first_fit_arena_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit allocator over an address-ordered block table held in a ring of
// cells; frees merge with free neighbors.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  kind, request_size, block_address
//  rsp      out        rsp_valid/rsp_stall  status, data_address
//
//  an allocate or free on a non-empty table makes one full turn of the
//  128-cell chain past the head cell, then the finish and update states
//  an item on an empty table, a release or an unused kind skips the scan
//  reset clears the block count and the response; cell contents need no reset
//  req_stall is high while an item is in work; a stalled response holds the
//  next item in the response state until the response register is taken
// ----------------------------------------------------------------------------
module first_fit_arena_allocator import ffa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [FIELD_W-1:0] req_request_size,
   input  logic [FIELD_W-1:0] req_block_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [FIELD_W-1:0] rsp_data_address
);

   cell_cmd_type cmd;
   entry_type    cell_entries [MAX_BLOCKS];

   ffa_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_request_size  (req_request_size),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_address  (rsp_data_address),
      .head              (cell_entries[0]),
      .cmd               (cmd)
   );

   // each cell takes from its upper neighbor; the top one wraps to the head
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffa_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_idx   (IDX_W'(i)),
         .next_entry (cell_entries[(i + 1) % MAX_BLOCKS]),
         .entry      (cell_entries[i])
      );
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for first_fit_arena_allocator: a local model of the
// block table predicts status and address of every request, and each response
// is compared with the oldest prediction under varying sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import ffa_pkg::*;

   typedef struct {
      status_type       status;
      logic [FIELD_W-1:0] addr;
   } grant_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_kind;
   logic [FIELD_W-1:0] req_request_size;
   logic [FIELD_W-1:0] req_block_address;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [FIELD_W-1:0] rsp_data_address;

   // local copy of the block table
   bit                 arena_up;
   int                 blk_count;
   logic [OFF_W-1:0]   blk_off  [MAX_BLOCKS];
   logic [OFF_W-1:0]   blk_cap  [MAX_BLOCKS];
   bit                 blk_busy [MAX_BLOCKS];

   grant_type          pending_grants[$];
   int                 mismatches = 0;
   int                 responses_checked = 0;
   int                 requests_sent;
   int                 idle_cycles = 0;
   int                 send_idle_pct;
   int                 stall_pct;
   // hold-off request from the test, counted down by the receiver
   int                 hold_cycles;
   int                 hold_seq;
   int                 hold_seen = 0;
   int                 hold_left = 0;

   first_fit_arena_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_request_size (req_request_size),
      .req_block_address(req_block_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_data_address (rsp_data_address)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void drop_block(int idx);
      for (int k = idx; k + 1 < blk_count; k++) begin
         blk_off[k]  = blk_off[k+1];
         blk_cap[k]  = blk_cap[k+1];
         blk_busy[k] = blk_busy[k+1];
      end
      blk_count--;
   endfunction

   function automatic grant_type grant_alloc(int size);
      grant_type g;
      int        last;
      int        off;
      g.status = STATUS_OK;
      g.addr   = '0;
      if (!arena_up || blk_count == 0) begin
         if (HEADER_BYTES + size > ARENA_BYTES - 1) begin
            g.status = STATUS_TOO_LARGE;
            return g;
         end
         blk_off[0] = '0; blk_cap[0] = OFF_W'(size); blk_busy[0] = 1;
         blk_count = 1;
         arena_up  = 1;
         g.addr    = FIELD_W'(HEADER_BYTES);
         return g;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (!blk_busy[i] && int'(blk_cap[i]) == size) begin
            blk_busy[i] = 1;
            g.addr = FIELD_W'(int'(blk_off[i]) + HEADER_BYTES);
            return g;
         end
         // free tail block big enough gets shrunk
         if (!blk_busy[i] && int'(blk_cap[i]) >= size && i + 1 == blk_count) begin
            blk_busy[i] = 1;
            blk_cap[i]  = OFF_W'(size);
            g.addr = FIELD_W'(int'(blk_off[i]) + HEADER_BYTES);
            return g;
         end
      end
      last = blk_count - 1;
      if (int'(blk_off[last]) + 2 * HEADER_BYTES + int'(blk_cap[last]) + size
          > ARENA_BYTES - 1 || blk_count >= MAX_BLOCKS) begin
         g.status = STATUS_TOO_LARGE;
         return g;
      end
      off = int'(blk_off[last]) + HEADER_BYTES + int'(blk_cap[last]);
      blk_off[blk_count]  = OFF_W'(off);
      blk_cap[blk_count]  = OFF_W'(size);
      blk_busy[blk_count] = 1;
      blk_count++;
      g.addr = FIELD_W'(off + HEADER_BYTES);
      return g;
   endfunction

   function automatic status_type release_block(int address);
      int idx;
      idx = -1;
      if (!arena_up) return STATUS_NOT_ALLOCATED;
      for (int i = 0; i < blk_count; i++)
         if (int'(blk_off[i]) + HEADER_BYTES == address) begin
            idx = i;
            break;
         end
      if (idx < 0) return STATUS_NOT_ALLOCATED;
      if (!blk_busy[idx]) return STATUS_ALREADY_FREED;
      blk_busy[idx] = 0;
      if (idx + 1 < blk_count && !blk_busy[idx+1]) begin
         blk_cap[idx] = OFF_W'(int'(blk_cap[idx]) + int'(blk_cap[idx+1]) + HEADER_BYTES);
         drop_block(idx + 1);
      end
      if (idx > 0 && !blk_busy[idx-1]) begin
         blk_cap[idx-1] = OFF_W'(int'(blk_cap[idx-1]) + int'(blk_cap[idx]) + HEADER_BYTES);
         drop_block(idx);
      end
      return STATUS_OK;
   endfunction

   function automatic grant_type predict_grant(kind_type kind, int size, int address);
      grant_type g;
      g.status = STATUS_OK;
      g.addr   = '0;
      case (kind)
         KIND_ALLOC: begin
            g = grant_alloc(size);
            if (g.status != STATUS_OK) g.addr = '0;
         end
         KIND_FREE:    g.status = release_block(address);
         KIND_RELEASE: begin
            arena_up  = 0;
            blk_count = 0;
         end
         default: ;
      endcase
      return g;
   endfunction

   task automatic send_item(kind_type kind, int size, int address);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_kind          = kind;
      req_request_size  = FIELD_W'(size);
      req_block_address = FIELD_W'(address);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_grants.push_back(predict_grant(kind, size, address));
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_grants.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random stalls plus an optional counted hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else begin
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_cycles;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      grant_type g;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) idle_cycles = 0;
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            responses_checked++;
            if (pending_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response status=%0d addr=%0d",
                           rsp_status, rsp_data_address);
            end else begin
               g = pending_grants.pop_front();
               if (rsp_status !== g.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("status mismatch: expected %0d actual %0d",
                              g.status, rsp_status);
               end
               if (rsp_data_address !== g.addr) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("address mismatch: expected %0d actual %0d",
                              g.addr, rsp_data_address);
               end
            end
         end
         if (idle_cycles >= 20000) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic int pick_block(bit want_busy);
      int hits[$];
      for (int i = 0; i < blk_count; i++)
         if (blk_busy[i] == want_busy) hits.push_back(i);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   task automatic send_random_item();
      int r;
      int idx;
      int size;
      r = $urandom_range(99);
      if (r < 52) begin
         r = $urandom_range(99);
         idx = pick_block(0);
         if (r < 15 && idx >= 0)      size = blk_cap[idx];
         else if (r < 80)             size = $urandom_range(120);
         else if (r < 94)             size = $urandom_range(1500, 200);
         else                         size = $urandom_range(4095);
         send_item(KIND_ALLOC, size, $urandom_range(4095));
      end else if (r < 96) begin
         r = $urandom_range(99);
         idx = (r < 65) ? pick_block(1) : (r < 80) ? pick_block(0) : -1;
         send_item(KIND_FREE, $urandom_range(4095),
                   idx >= 0 ? int'(blk_off[idx]) + HEADER_BYTES : $urandom_range(4095));
      end else if (r < 98) begin
         send_item(KIND_NONE, $urandom_range(4095), $urandom_range(4095));
      end else begin
         send_item(KIND_RELEASE, $urandom_range(4095), $urandom_range(4095));
      end
   endtask

   task automatic test_directed();
      send_item(KIND_FREE, 0, HEADER_BYTES);         // free on empty arena
      send_item(KIND_ALLOC, 4095, 0);                // too large on empty
      send_item(KIND_ALLOC, 4064, 0);                // one past the fit limit
      send_item(KIND_ALLOC, 4063, 4095);             // exactly fits
      send_item(KIND_ALLOC, 0, 0);                   // no room to append
      send_item(KIND_FREE, 0, HEADER_BYTES);
      send_item(KIND_FREE, 0, HEADER_BYTES);         // double free
      send_item(KIND_ALLOC, 100, 0);                 // tail shrink
      send_item(KIND_ALLOC, 0, 0);                   // zero size append
      send_item(KIND_ALLOC, 64, 0);
      send_item(KIND_ALLOC, 16, 0);
      send_item(KIND_FREE, 0, 4095);                 // unknown address
      send_item(KIND_FREE, 0, 164);                  // free middle block
      send_item(KIND_FREE, 0, 292);                  // free the tail
      send_item(KIND_FREE, 0, 196);                  // merge both sides
      send_item(KIND_ALLOC, 0, 0);
      send_item(KIND_FREE, 0, 164);
      send_item(KIND_ALLOC, 0, 0);                   // exact fit reuse
      send_item(KIND_NONE, 4095, 4095);
      send_item(KIND_RELEASE, 4095, 4095);
      send_item(KIND_FREE, 0, HEADER_BYTES);         // gone after release
      send_item(KIND_ALLOC, 7, 0);
      wait_drained();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_rate);
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      repeat (count) send_random_item();
      send_idle_pct = 0;
      stall_pct     = 0;
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_cycles = 1500;
      hold_seq++;
      repeat (12) send_random_item();
      wait_drained();
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_ALLOC;
      req_request_size  = '0;
      req_block_address = '0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_cycles       = 0;
      hold_seq          = 0;
      requests_sent     = 0;
      arena_up          = 0;
      blk_count         = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(210, 0, 0);
      test_random(210, 58, 0);
      test_random(210, 0, 58);
      test_random(210, 19, 19);
      test_backpressure();

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("sent %0d requests, checked %0d responses", requests_sent,
               responses_checked);
      $display("covered fit limits, exact and tail fits, merges, double free, release");
      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/ffa_ctrl.sv
sv/first_fit_arena_allocator.sv
test/tb_top.sv
